// ----- rtl/scba_pkg.sv -----
// Package: shared types and constants for the size-class block allocator.
package scba_pkg;

  localparam int unsigned ADDR_W    = 19;
  localparam int unsigned BYTES_W   = 16;
  localparam int unsigned HOME_W    = 2;
  localparam int unsigned STATUS_W  = 2;

  typedef enum logic [0:0] {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_PAGES = 2'd1,
    ST_TOO_BIG  = 2'd2,
    ST_BAD_FREE = 2'd3
  } status_t;

endpackage

// ----- rtl/scba_if.sv -----
// Interfaces: request and response channels of the allocator.
interface scba_req_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [scba_pkg::BYTES_W-1:0] request_bytes;
  logic [scba_pkg::HOME_W-1:0]  home_heap;
  logic [scba_pkg::ADDR_W-1:0]  free_address;
  modport source (output valid, func, request_bytes, home_heap, free_address, input ready);
  modport sink   (input valid, func, request_bytes, home_heap, free_address, output ready);
endinterface

interface scba_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [scba_pkg::ADDR_W-1:0]   block_address;
  logic [scba_pkg::STATUS_W-1:0] status;
  modport source (output valid, block_address, status, input ready);
  modport sink   (input valid, block_address, status, output ready);
endinterface

// ----- rtl/scba_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
module scba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/size_class_block_allocator.sv -----
// Top level: size-class block allocator with per-heap LIFO free stacks.
//  channel | dir | handshake   | payload
//  req     | in  | valid/ready | func, request_bytes, home_heap, free_address
//  rsp     | out | valid/ready | block_address, status
// One request at a time. Allocate reads the slot memory and decides on each heap probed,
// then pops or carves (link read or slot write back) before the response is valid;
// it stops with out of pages after the last heap, and responds without a probe
// when too big. Free reads the slot and writes slot and link back, or responds
// directly when null or bad. The slot memory holds stack head, carve count and
// carve page. Reset clears the slot valid bits and the page count.
// A pending response holds until taken; the next request can be taken in the cycle after.
module size_class_block_allocator #(
  parameter int unsigned HEAPS        = 4,
  parameter int unsigned NUM_PAGES    = 16,
  parameter int unsigned PAGE_POWER   = 15,
  parameter int unsigned MIN_POWER    = 3,
  parameter int unsigned HEADER_BYTES = 2
) (
  input logic         clk,
  input logic         rst,
  scba_req_if.sink    req,
  scba_rsp_if.source  rsp
);
  localparam int unsigned CLASSES   = PAGE_POWER + 1;
  localparam int unsigned CLS_W     = $clog2(CLASSES);
  localparam int unsigned HEAP_W    = (HEAPS > 1) ? $clog2(HEAPS) : 1;
  localparam int unsigned SLOTS     = (1 << HEAP_W) * (1 << CLS_W);
  localparam int unsigned SLOT_W    = HEAP_W + CLS_W;
  localparam int unsigned PAGE_W    = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int unsigned PCNT_W    = $clog2(NUM_PAGES + 1);
  localparam int unsigned BLK_W     = PAGE_W + PAGE_POWER - MIN_POWER;
  localparam int unsigned BLOCKS    = (1 << BLK_W);
  localparam int unsigned LINK_W    = BLK_W + 1;
  localparam int unsigned LEFT_W    = PAGE_POWER - MIN_POWER + 1;
  localparam int unsigned SLOTD_W   = LINK_W + LEFT_W + PAGE_W;
  localparam int unsigned WIDE_W    = 28;
  localparam int unsigned AW        = scba_pkg::ADDR_W;

  typedef enum logic [3:0] {
    S_IDLE, S_SREAD, S_SDEC, S_LREAD, S_PREAD, S_FCHK, S_FREAD, S_FWRITE, S_RESP
  } state_t;

  typedef struct packed {
    logic [LINK_W-1:0] head;
    logic [LEFT_W-1:0] left;
    logic [PAGE_W-1:0] page;
  } slot_t;

  state_t                state;
  logic [CLS_W-1:0]      cls;
  logic [HEAP_W-1:0]     heap;
  logic [HEAP_W:0]       tries;
  logic [AW-1:0]         addr;
  logic [PCNT_W-1:0]     pages_used;
  logic [SLOTS-1:0]      slot_valid;
  logic [AW-1:0]         out_addr;
  scba_pkg::status_t     out_status;
  slot_t                 cur;
  logic [BLK_W-1:0]      pop_idx;
  logic [CLS_W-1:0]      page_class [NUM_PAGES];
  logic [HEAP_W-1:0]     page_owner [NUM_PAGES];

  logic                  s_we;
  logic [SLOT_W-1:0]     s_waddr, s_raddr;
  slot_t                 s_wdata, s_rdata;
  logic                  l_we;
  logic [BLK_W-1:0]      l_waddr, l_raddr;
  logic [LINK_W-1:0]     l_wdata, l_rdata;

  scba_ram #(.WIDTH(SLOTD_W), .DEPTH(SLOTS)) u_slot (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr), .rdata(s_rdata)
  );
  scba_ram #(.WIDTH(LINK_W), .DEPTH(BLOCKS)) u_link (
    .clk, .we(l_we), .waddr(l_waddr), .wdata(l_wdata), .raddr(l_raddr), .rdata(l_rdata)
  );

  logic [SLOT_W-1:0] slot_idx;
  assign slot_idx = {heap, cls};

  // class selection for the incoming request
  logic [16:0]       need;
  logic [CLS_W-1:0]  req_cls;
  logic              req_big;
  assign need    = {1'b0, req.request_bytes} + 17'(HEADER_BYTES);
  assign req_big = {11'd0, need} > (WIDE_W'(1) << PAGE_POWER);
  always_comb begin
    req_cls = CLS_W'(PAGE_POWER);
    for (int c = PAGE_POWER; c >= int'(MIN_POWER); c--) begin
      if ({11'd0, need} <= (WIDE_W'(1) << c)) begin
        req_cls = CLS_W'(c);
      end
    end
  end

  // reduce the home heap into range
  logic [HEAP_W-1:0] req_heap;
  always_comb begin
    int unsigned h;
    h = 32'(req.home_heap);
    for (int k = 0; k < 4; k++) begin
      if (h >= HEAPS) begin
        h = h - HEAPS;
      end
    end
    req_heap = HEAP_W'(h);
  end

  // free address decode
  logic [AW-1:0]     fbase;
  logic [PAGE_W-1:0] fpage;
  logic              fpage_ok;
  logic [WIDE_W-1:0] fmask;
  assign fbase    = addr - AW'(HEADER_BYTES);
  assign fpage    = PAGE_W'({9'd0, fbase} >> PAGE_POWER);
  assign fpage_ok = ({9'd0, fbase} >> PAGE_POWER) < WIDE_W'(pages_used);
  assign fmask    = (WIDE_W'(1) << page_class[fpage]) - WIDE_W'(1);

  slot_t cur_rd;
  assign cur_rd = slot_valid[s_raddr] ? s_rdata : '0;

  slot_t cur_upd;
  always_comb begin
    cur_upd = cur_rd;
    if (cur_rd.head == '0) begin
      if (cur_rd.left == '0) begin
        cur_upd.page = PAGE_W'(pages_used);
        cur_upd.left = LEFT_W'(WIDE_W'(1) << (PAGE_POWER - cls)) - LEFT_W'(1);
      end else begin
        cur_upd.left = cur_rd.left - LEFT_W'(1);
      end
    end
  end

  logic [WIDE_W-1:0] carve_base;
  assign carve_base = (WIDE_W'(cur_upd.page) << PAGE_POWER) +
                      (WIDE_W'(cur_upd.left) << cls);

  always_comb begin
    s_raddr = slot_idx;
    s_we    = 1'b0;
    s_waddr = slot_idx;
    s_wdata = cur;
    l_we    = 1'b0;
    l_waddr = pop_idx;
    l_wdata = cur.head;
    l_raddr = pop_idx;
    if (state == S_SDEC && cur_rd.head != '0) begin
      l_raddr = BLK_W'(cur_rd.head - LINK_W'(1));
    end
    if (state == S_LREAD) begin
      s_we          = 1'b1;
      s_wdata.head  = l_rdata;
    end
    if (state == S_PREAD) begin
      s_we = 1'b1;
    end
    if (state == S_FWRITE) begin
      s_we         = 1'b1;
      s_wdata      = cur_rd;
      s_wdata.head = LINK_W'(pop_idx) + LINK_W'(1);
      l_we         = 1'b1;
      l_wdata      = cur_rd.head;
    end
  end

  assign req.ready     = (state == S_IDLE);
  assign rsp.valid     = (state == S_RESP);
  assign rsp.block_address = out_addr;
  assign rsp.status    = out_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pages_used <= '0;
      slot_valid <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            addr       <= req.free_address;
            cls        <= req_cls;
            heap       <= req_heap;
            tries      <= '0;
            out_addr   <= '0;
            if (req.func == scba_pkg::FUNC_ALLOC) begin
              if (req_big) begin
                out_status <= scba_pkg::ST_TOO_BIG;
                state      <= S_RESP;
              end else begin
                out_status <= scba_pkg::ST_OK;
                state      <= S_SREAD;
              end
            end else begin
              out_status <= scba_pkg::ST_OK;
              state      <= S_FCHK;
            end
          end
        end
        S_SREAD: state <= S_SDEC;
        S_SDEC: begin
          cur <= cur_upd;
          if (cur_rd.head != '0) begin
            pop_idx <= BLK_W'(cur_rd.head - LINK_W'(1));
            state   <= S_LREAD;
          end else if (cur_rd.left != '0 || pages_used < PCNT_W'(NUM_PAGES)) begin
            if (cur_rd.left == '0) begin
              page_class[PAGE_W'(pages_used)] <= cls;
              page_owner[PAGE_W'(pages_used)] <= heap;
              pages_used <= pages_used + PCNT_W'(1);
            end
            out_addr <= AW'(carve_base + WIDE_W'(HEADER_BYTES));
            state    <= S_PREAD;
          end else if (tries == (HEAP_W+1)'(HEAPS - 1)) begin
            out_status <= scba_pkg::ST_NO_PAGES;
            state      <= S_RESP;
          end else begin
            tries <= tries + 1'b1;
            heap  <= (32'(heap) == HEAPS - 1) ? '0 : heap + 1'b1;
            state <= S_SREAD;
          end
        end
        S_LREAD: begin
          slot_valid[slot_idx] <= 1'b1;
          out_addr <= AW'((WIDE_W'(pop_idx) << MIN_POWER) + WIDE_W'(HEADER_BYTES));
          state    <= S_RESP;
        end
        S_PREAD: begin
          slot_valid[slot_idx] <= 1'b1;
          state <= S_RESP;
        end
        S_FCHK: begin
          if (addr == '0) begin
            state <= S_RESP;
          end else if (addr < AW'(HEADER_BYTES) || !fpage_ok ||
                       (WIDE_W'(fbase) & fmask) != '0) begin
            out_status <= scba_pkg::ST_BAD_FREE;
            state      <= S_RESP;
          end else begin
            cls     <= page_class[fpage];
            heap    <= page_owner[fpage];
            pop_idx <= BLK_W'(fbase >> MIN_POWER);
            state   <= S_FREAD;
          end
        end
        S_FREAD: state <= S_FWRITE;
        S_FWRITE: begin
          slot_valid[slot_idx] <= 1'b1;
          state <= S_RESP;
        end
        S_RESP: begin
          if (rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/scba_checker.sv -----
// Checker: port-level properties of the allocator, bound to the top level.
module scba_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [scba_pkg::ADDR_W-1:0]   rsp_addr,
  input logic [scba_pkg::STATUS_W-1:0] rsp_status
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_addr))
    else $error("response dropped while stalled");
  a_one: assert property (@(posedge clk) disable iff (rst)
    !(req_ready && rsp_valid))
    else $error("request taken with response pending");
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != scba_pkg::ST_OK |-> rsp_addr == '0)
    else $error("failed request carries an address");
  a_gap: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");
endmodule

bind size_class_block_allocator scba_checker u_scba_checker (
  .clk(clk), .rst(rst),
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .rsp_addr(rsp.block_address), .rsp_status(rsp.status)
);
